[rtl/hkrt_pkg.sv]
// Shared types, constants and helpers for the HID keyboard report tracker.
package hkrt_pkg;

    // Slots that appear in one emitted report
    localparam int unsigned OUT_SLOTS     = 6;
    // Default number of tracked key slots
    localparam int unsigned KEY_SLOTS_DEF = 6;

    localparam logic [7:0] KEY_NONE   = 8'h00;
    // Usages E0..E7 are the eight modifier keys
    localparam logic [4:0] MOD_PREFIX = 5'b11100;

    // Per-cycle result of the shared slot comparator
    typedef struct packed {
        logic hit;    // slot holds the key under test
        logic empty;  // slot is free
    } t_scan_stat;

    // Modifier bit selected by a usage code, zero for ordinary keys
    function automatic logic [7:0] mod_mask(input logic [7:0] usage);
        logic [7:0] m;
        m = 8'h00;
        if (usage[7:3] == MOD_PREFIX) begin
            m = 8'h01 << usage[2:0];
        end
        return m;
    endfunction

endpackage

[rtl/hkrt_if.sv]
// Handshake channels: key events in, boot-keyboard reports out.
interface hkrt_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       is_release;

    modport source (output valid, key_code, is_release, input ready);
    modport sink   (input valid, key_code, is_release, output ready);
endinterface

interface hkrt_rpt_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;

    modport source (output valid, modifiers, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, input ready);
    modport sink   (input valid, modifiers, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

[rtl/hkrt_slot_scan.sv]
// Key slot registers with the single shared comparator used by the scan.
module hkrt_slot_scan
    import hkrt_pkg::*;
#(
    parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF,
    localparam int unsigned IDX_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  logic [7:0]       i_code,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [7:0]       i_wr_data,
    output t_scan_stat       o_stat,
    output logic [7:0]       o_keys [KEY_SLOTS]
);

    logic [7:0] r_keys [KEY_SLOTS];
    logic [7:0] rd_data;

    // Slot storage, all empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_keys[i] <= KEY_NONE;
            end
        end else if (i_wr_en) begin
            r_keys[i_wr_idx] <= i_wr_data;
        end
    end

    // Shared compare against the slot under the scan pointer
    assign rd_data      = r_keys[i_rd_idx];
    assign o_stat.hit   = (rd_data == i_code);
    assign o_stat.empty = (rd_data == KEY_NONE);

    assign o_keys = r_keys;

endmodule

[rtl/hid_keyboard_report_tracker.sv]
// Top level: HID boot-keyboard report tracker with a slot-scan sequencer.
//
// Usage:
//   i_key (sink) takes one key event per request: key_code and is_release.
//   o_rpt (source) gives the updated report (modifier byte, six key slots)
//   whenever a key slot changes; events that change no slot give nothing.
//   Each accepted event is handled by a sequencer that walks the KEY_SLOTS
//   slot registers through one shared 8-bit comparator, one slot a cycle.
//   A code-zero event is dropped on acceptance; other events pass through
//   the states SCAN and APPLY, and EMIT then loads the report register when
//   a slot changed.
//   i_key.ready is high only while the sequencer is idle.
//   A finished report sits in an output register; the next event is accepted
//   and scanned while it waits. If the receiver still stalls when a new
//   report is ready, the sequencer holds until the register frees up.
//   Reset (synchronous, active low) empties all slots, clears the modifiers
//   and drops any pending report.
module hid_keyboard_report_tracker
    import hkrt_pkg::*;
#(
    parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hkrt_key_if.sink   i_key,
    hkrt_rpt_if.source o_rpt
);

    localparam int unsigned IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_code;
    logic             r_rel;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_emp, n_emp;
    logic [IDX_W-1:0] r_emp_idx, n_emp_idx;
    logic [7:0]       r_mods, n_mods;

    logic             r_out_valid;
    logic [7:0]       r_out_mods;
    logic [7:0]       r_out_keys [OUT_SLOTS];

    t_scan_stat       stat;
    logic [7:0]       keys [KEY_SLOTS];
    logic [7:0]       rpt_keys [OUT_SLOTS];
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;
    logic             in_fire;
    logic             out_free;

    hkrt_slot_scan #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_slot_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (r_idx),
        .i_code    (r_code),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .o_stat    (stat),
        .o_keys    (keys)
    );

    assign i_key.ready = (r_state == S_IDLE);
    assign in_fire     = i_key.valid && i_key.ready;
    assign out_free    = !r_out_valid || o_rpt.ready;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_emp     = r_emp;
        n_emp_idx = r_emp_idx;
        n_mods    = r_mods;
        wr_en     = 1'b0;
        wr_idx    = r_hit_idx;
        wr_data   = KEY_NONE;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_hit = 1'b0;
                n_emp = 1'b0;
                // code zero is dropped here
                if (in_fire && (i_key.key_code != KEY_NONE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // remember the first holding slot and the first free slot
                if (stat.hit && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                end
                if (stat.empty && !r_emp) begin
                    n_emp     = 1'b1;
                    n_emp_idx = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_APPLY;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_APPLY: begin
                n_state = S_IDLE;
                if (r_rel) begin
                    n_mods = r_mods & ~mod_mask(r_code);
                    if (r_hit) begin
                        wr_en   = 1'b1;
                        wr_idx  = r_hit_idx;
                        wr_data = KEY_NONE;
                        n_state = S_EMIT;
                    end
                end else if (!r_hit) begin
                    n_mods = r_mods | mod_mask(r_code);
                    if (r_emp) begin
                        wr_en   = 1'b1;
                        wr_idx  = r_emp_idx;
                        wr_data = r_code;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and held modifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_emp   <= 1'b0;
            r_mods  <= 8'h00;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hit   <= n_hit;
            r_emp   <= n_emp;
            r_mods  <= n_mods;
        end
    end

    // Event capture and scan positions
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_code <= i_key.key_code;
            r_rel  <= i_key.is_release;
        end
        r_hit_idx <= n_hit_idx;
        r_emp_idx <= n_emp_idx;
    end

    // Report view of the slots: missing slots read as empty
    for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_rpt
        if (j < KEY_SLOTS) begin : g_have
            assign rpt_keys[j] = keys[j];
        end else begin : g_none
            assign rpt_keys[j] = KEY_NONE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rpt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_mods <= r_mods;
            r_out_keys <= rpt_keys;
        end
    end

    assign o_rpt.valid      = r_out_valid;
    assign o_rpt.modifiers  = r_out_mods;
    assign o_rpt.key_slot_0 = r_out_keys[0];
    assign o_rpt.key_slot_1 = r_out_keys[1];
    assign o_rpt.key_slot_2 = r_out_keys[2];
    assign o_rpt.key_slot_3 = r_out_keys[3];
    assign o_rpt.key_slot_4 = r_out_keys[4];
    assign o_rpt.key_slot_5 = r_out_keys[5];

endmodule
